// File: sv/mpwr_pkg.sv
// shared types and constants for the pulse width receiver
package mpwr_pkg;

    localparam int unsigned CFG_W = 8;

    // configuration register indexes
    localparam logic CFG_ONE_THRESHOLD = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [CFG_W-1:0] ONE_THRESHOLD_RESET = 8'd22;
    localparam logic [CFG_W-1:0] TIMEOUT_TICKS_RESET = 8'd70;

    typedef struct packed {
        logic       nibble_valid;
        logic [3:0] nibble_value;
        logic [3:0] nibble_index;
        logic       frame_end;
        logic [4:0] frame_length;
        logic       busy_res;
    } result_t;

endpackage

// File: sv/mpwr_core.sv
// receiver state and per-sample decode: edges, pulse timer, nibble and frame counting
module mpwr_core #(
    parameter int unsigned FRAME_NIBBLES = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   level,
    input  logic [7:0]             one_threshold,
    input  logic [7:0]             timeout_ticks,
    output mpwr_pkg::result_t      result
);
    import mpwr_pkg::*;

    localparam int unsigned NIB_W = $clog2(FRAME_NIBBLES);
    localparam logic [NIB_W-1:0] LAST_NIB = NIB_W'(FRAME_NIBBLES - 1);
    localparam logic [4:0] FRAME_LEN = 5'(FRAME_NIBBLES);

    logic             prev_reg,   prev_next;
    logic [7:0]       tick_reg,   tick_next;
    logic             active_reg, active_next;
    logic [2:0]       shift_reg,  shift_next;
    logic [1:0]       bits_reg,   bits_next;
    logic [NIB_W-1:0] nib_reg,    nib_next;
    logic             busy_reg,   busy_next;

    logic             rising;
    logic             falling;
    logic             bit_val;
    logic [7:0]       nib_ext;
    logic [7:0]       nib_next_ext;

    assign rising       = level & ~prev_reg;
    assign falling      = ~level & prev_reg;
    assign nib_ext      = 8'(nib_reg);

    always_comb
    begin
        prev_next   = level;
        tick_next   = tick_reg;
        active_next = active_reg;
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        nib_next    = nib_reg;
        busy_next   = busy_reg;
        result      = '0;
        bit_val     = 1'b0;
        nib_next_ext = '0;

        if (rising)
        begin
            tick_next   = '0;
            active_next = 1'b1;
            busy_next   = 1'b1;
        end
        else if (active_reg && (tick_reg != 8'hFF))
        begin
            tick_next = tick_reg + 8'd1;
        end

        if (falling)
        begin
            bit_val   = (tick_next > one_threshold);
            busy_next = 1'b1;
            if (bits_reg == 2'd3)
            begin
                result.nibble_valid = 1'b1;
                result.nibble_value = {shift_reg, bit_val};
                result.nibble_index = nib_ext[3:0];
                shift_next = '0;
                bits_next  = '0;
                if (nib_reg == LAST_NIB)
                begin
                    result.frame_end    = 1'b1;
                    result.frame_length = FRAME_LEN;
                    nib_next  = '0;
                    busy_next = 1'b0;
                end
                else
                begin
                    nib_next = nib_reg + 1'b1;
                end
            end
            else
            begin
                shift_next = {shift_reg[1:0], bit_val};
                bits_next  = bits_reg + 2'd1;
            end
        end

        // timeout ends the frame, reported only with nibbles pending
        if (active_next && (tick_next >= timeout_ticks))
        begin
            nib_next_ext = 8'(nib_next);
            if (nib_next != '0)
            begin
                result.frame_end    = 1'b1;
                result.frame_length = nib_next_ext[4:0];
            end
            active_next = 1'b0;
            tick_next   = '0;
            shift_next  = '0;
            bits_next   = '0;
            nib_next    = '0;
            busy_next   = 1'b0;
        end

        result.busy_res = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b0;
            tick_reg   <= '0;
            active_reg <= 1'b0;
            shift_reg  <= '0;
            bits_reg   <= '0;
            nib_reg    <= '0;
            busy_reg   <= 1'b0;
        end
        else if (step)
        begin
            prev_reg   <= prev_next;
            tick_reg   <= tick_next;
            active_reg <= active_next;
            shift_reg  <= shift_next;
            bits_reg   <= bits_next;
            nib_reg    <= nib_next;
            busy_reg   <= busy_next;
        end
    end

endmodule

// File: sv/mbus_pulse_width_receiver.sv
// pulse width receiver top: input register, decode core, result register, config registers
// a sample word accepted into the input register is decoded and its result word is captured in the result register
// throughput: one sample word per cycle, set by the combinational decode between the
//   input register and the result register; a held result stalls the input once the
//   input register holds a word
// reset: asynchronous, clears receiver state, the valid flags of both stages and restores threshold 22,
//   timeout 70
module mbus_pulse_width_receiver #(
    parameter int unsigned FRAME_NIBBLES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       line_level,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       nibble_valid,
    output logic [3:0] nibble_value,
    output logic [3:0] nibble_index,
    output logic       frame_end,
    output logic [4:0] frame_length,
    output logic       busy_res,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    import mpwr_pkg::*;

    logic             in_valid_reg;
    logic             level_reg;
    logic             out_valid_reg;
    result_t          result_reg;
    result_t          core_result;
    logic [CFG_W-1:0] one_threshold_reg;
    logic [CFG_W-1:0] timeout_ticks_reg;
    logic             advance;
    logic             step;

    assign advance  = ~out_valid_reg | out_ready;
    assign step     = in_valid_reg & advance;
    assign in_ready = ~in_valid_reg | advance;

    mpwr_core #(
        .FRAME_NIBBLES (FRAME_NIBBLES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .level         (level_reg),
        .one_threshold (one_threshold_reg),
        .timeout_ticks (timeout_ticks_reg),
        .result        (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            level_reg <= line_level;
        end
        if (step)
        begin
            result_reg <= core_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_threshold_reg <= ONE_THRESHOLD_RESET;
            timeout_ticks_reg <= TIMEOUT_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ONE_THRESHOLD: one_threshold_reg <= cfg_data;
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:           one_threshold_reg <= one_threshold_reg;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign nibble_valid = result_reg.nibble_valid;
    assign nibble_value = result_reg.nibble_value;
    assign nibble_index = result_reg.nibble_index;
    assign frame_end    = result_reg.frame_end;
    assign frame_length = result_reg.frame_length;
    assign busy_res     = result_reg.busy_res;

endmodule
